### rtl/core/hkst_pkg.sv
// shared types and constants for the held key shift table
`timescale 1ns / 1ps
`default_nettype none

package hkst_pkg;

   // width of the key code fields on the channels
   localparam int CODE_BITS = 8;
   localparam int ACTION_BITS = 2;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_PUSH   = 2'd0,
      ACT_POP    = 2'd1,
      ACT_DELETE = 2'd2,
      ACT_QUERY  = 2'd3
   } action_type;

   // command from the front register to the slot row
   typedef struct packed {
      logic       fire;
      action_type action;
   } row_cmd_type;

endpackage

`default_nettype wire

### rtl/core/hkst_if.sv
// channel interfaces: request, response and csr write
`timescale 1ns / 1ps
`default_nettype none

interface hkst_req_if;
   logic                            valid;
   logic                            ready;
   logic [hkst_pkg::ACTION_BITS-1:0] action;
   logic [hkst_pkg::CODE_BITS-1:0]   key_code;

   modport source (output valid, output action, output key_code, input ready);
   modport sink (input valid, input action, input key_code, output ready);
endinterface

interface hkst_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [hkst_pkg::CODE_BITS-1:0] key_out;
   logic                          found;

   modport source (output valid, output key_out, output found, input ready);
   modport sink (input valid, input key_out, input found, output ready);
endinterface

interface hkst_csr_if;
   logic                          valid;
   logic                          ready;
   logic [hkst_pkg::CODE_BITS-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/hkst_slot_row.sv
// slot row: storage plus push, pop, stable compaction and presence compare
`timescale 1ns / 1ps
`default_nettype none

module hkst_slot_row #(
   parameter int SLOT_COUNT = 8,
   parameter int KEY_BITS   = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire hkst_pkg::row_cmd_type cmd,
   input  wire logic [KEY_BITS-1:0]  code,
   input  wire logic [KEY_BITS-1:0]  empty_code,
   output logic      [KEY_BITS-1:0]  top_key,
   output logic                      hit
);

   localparam int RANK_BITS = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   logic [KEY_BITS-1:0]  slots_ff [SLOT_COUNT];
   logic [KEY_BITS-1:0]  slots_in [SLOT_COUNT];
   logic [KEY_BITS-1:0]  packed_row [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] keep;
   logic [SLOT_COUNT-1:0] match;
   logic [RANK_BITS-1:0] rank [SLOT_COUNT];

   always_comb begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         match[i] = (slots_ff[i] == code);
         keep[i]  = !match[i] && (slots_ff[i] != empty_code);
      end
   end

   assign hit     = |match;
   assign top_key = slots_ff[SLOT_COUNT-1];

   // number of kept entries above each slot gives its distance from the top
   always_comb begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         rank[i] = RANK_BITS'($countones(keep & ({SLOT_COUNT{1'b1}} << (i + 1))));
      end
   end

   always_comb begin
      logic [KEY_BITS-1:0] pick;
      logic                filled;
      pick   = '0;
      filled = 1'b0;
      for (int j = 0; j < SLOT_COUNT; j++) begin
         pick   = '0;
         filled = 1'b0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            if (keep[i] && ((SLOT_COUNT - 1 - int'(rank[i])) == j)) begin
               pick   = pick | slots_ff[i];
               filled = 1'b1;
            end
         end
         packed_row[j] = filled ? pick : empty_code;
      end
   end

   always_comb begin
      slots_in = slots_ff;
      unique case (cmd.action)
         hkst_pkg::ACT_PUSH: begin
            for (int i = 0; i < SLOT_COUNT - 1; i++) begin
               slots_in[i] = slots_ff[i+1];
            end
            slots_in[SLOT_COUNT-1] = code;
         end
         hkst_pkg::ACT_POP: begin
            for (int i = 1; i < SLOT_COUNT; i++) begin
               slots_in[i] = slots_ff[i-1];
            end
            slots_in[0] = empty_code;
         end
         hkst_pkg::ACT_DELETE: begin
            slots_in = packed_row;
         end
         hkst_pkg::ACT_QUERY: begin
            slots_in = slots_ff;
         end
         default: begin
            slots_in = slots_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slots_ff[i] <= '0;
         end
      end else if (cmd.fire) begin
         slots_ff <= slots_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_push_top: assert property (@(posedge clock) disable iff (reset)
      cmd.fire && cmd.action == hkst_pkg::ACT_PUSH
      |=> slots_ff[SLOT_COUNT-1] == $past(code))
      else $error("push did not land on top slot");

   a_pop_bottom: assert property (@(posedge clock) disable iff (reset)
      cmd.fire && cmd.action == hkst_pkg::ACT_POP
      |=> slots_ff[0] == $past(empty_code))
      else $error("pop did not refill bottom slot");

   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.fire |=> slots_ff[SLOT_COUNT-1] == $past(slots_ff[SLOT_COUNT-1]))
      else $error("slot row changed without a command");
`endif

endmodule

`default_nettype wire

### rtl/core/held_key_shift_table.sv
// held key shift table top level: front register, slot row, response register
//
//   channel  dir  handshake      payload
//   req_bus  in   valid/ready    action[1:0], key_code[7:0]
//   rsp_bus  out  valid/ready    key_out[7:0], found
//   csr_bus  in   valid/ready    data[7:0] (empty code)
//
// one transaction per cycle sustained while rsp_bus.ready stays high; a taken
// request goes to the front register, then the response register, to rsp_bus
// the slot row updates as the request moves from the front register to the
// response register, so back-to-back requests see each other's effects
// reset clears all slots and the empty code to zero; csr_bus is always ready
// a stalled response holds the pipeline; req_bus.ready drops once the front
// register is also full
`timescale 1ns / 1ps
`default_nettype none

module held_key_shift_table #(
   parameter int SLOT_COUNT = 8,
   parameter int KEY_BITS   = 8
) (
   input  wire logic clock,
   input  wire logic reset,
   hkst_req_if.sink   req_bus,
   hkst_rsp_if.source rsp_bus,
   hkst_csr_if.sink   csr_bus
);

   // bits of an 8-bit code that survive the cut to the slot width
   localparam int CUT_BITS = (KEY_BITS < hkst_pkg::CODE_BITS) ? KEY_BITS
                                                              : hkst_pkg::CODE_BITS;

   logic                  in_valid_ff;
   hkst_pkg::action_type  in_action_ff;
   logic [KEY_BITS-1:0]   in_code_ff;
   logic                  rsp_valid_ff;
   logic [hkst_pkg::CODE_BITS-1:0] rsp_key_ff;
   logic                  rsp_found_ff;
   logic [KEY_BITS-1:0]   empty_ff;

   logic                  advance;
   logic                  req_take;
   logic [KEY_BITS-1:0]   req_code_in;
   logic [KEY_BITS-1:0]   empty_in;
   logic [hkst_pkg::CODE_BITS-1:0] rsp_key_in;
   logic                  rsp_found_in;
   logic [KEY_BITS-1:0]   top_key;
   logic                  hit;
   hkst_pkg::row_cmd_type row_cmd;

   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign req_code_in = KEY_BITS'(req_bus.key_code[CUT_BITS-1:0]);
   assign empty_in    = KEY_BITS'(csr_bus.data[CUT_BITS-1:0]);

   assign row_cmd.fire   = in_valid_ff && advance;
   assign row_cmd.action = in_action_ff;

   hkst_slot_row #(
      .SLOT_COUNT (SLOT_COUNT),
      .KEY_BITS   (KEY_BITS)
   ) u_row (
      .clock      (clock),
      .reset      (reset),
      .cmd        (row_cmd),
      .code       (in_code_ff),
      .empty_code (empty_ff),
      .top_key    (top_key),
      .hit        (hit)
   );

   always_comb begin
      if (in_action_ff == hkst_pkg::ACT_POP) begin
         rsp_key_in = hkst_pkg::CODE_BITS'(top_key[CUT_BITS-1:0]);
      end else begin
         rsp_key_in = hkst_pkg::CODE_BITS'(in_code_ff[CUT_BITS-1:0]);
      end
      rsp_found_in = (in_action_ff == hkst_pkg::ACT_QUERY) && hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         empty_ff     <= '0;
      end else begin
         if (req_bus.ready) begin
            in_valid_ff <= req_bus.valid;
         end
         if (advance) begin
            rsp_valid_ff <= in_valid_ff;
         end
         if (csr_bus.valid) begin
            empty_ff <= empty_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_action_ff <= hkst_pkg::action_type'(req_bus.action);
         in_code_ff   <= req_code_in;
      end
      if (row_cmd.fire) begin
         rsp_key_ff   <= rsp_key_in;
         rsp_found_ff <= rsp_found_in;
      end
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.key_out = rsp_key_ff;
   assign rsp_bus.found   = rsp_found_ff;

`ifndef NO_ASSERTIONS
   a_fire_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      row_cmd.fire |=> rsp_valid_ff)
      else $error("command fired but no response registered");

   a_full_blocks_req: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && rsp_valid_ff && !rsp_bus.ready |-> !req_bus.ready)
      else $error("request taken while pipeline is full");

   a_found_only_query: assert property (@(posedge clock) disable iff (reset)
      row_cmd.fire && in_action_ff != hkst_pkg::ACT_QUERY |=> !rsp_found_ff)
      else $error("found set for a non-query transaction");
`endif

endmodule

`default_nettype wire
